[design/dmcts_pkg.sv]
// Shared types and constants of the direct-mapped cache tag store.
package dmcts_pkg;

  // Width of the reported evicted tag.
  localparam int unsigned EVICT_TAG_W = 8;

  // Width of the miss classification field.
  localparam int unsigned MISS_KIND_W = 2;

  typedef enum logic [MISS_KIND_W-1:0] {
    MISS_HIT        = 2'd0,
    MISS_COMPULSORY = 2'd1,
    MISS_CONFLICT   = 2'd2
  } miss_kind_e;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } command_e;

endpackage

[design/dmcts_if.sv]
// Valid/ready channel interfaces for cache access requests and their results.
interface dmcts_req_if #(
  parameter int unsigned ADDR_BITS = 20
);
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [ADDR_BITS-1:0] address;

  modport source (output valid, output command, output address, input ready);
  modport sink   (input valid, input command, input address, output ready);
endinterface

interface dmcts_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [dmcts_pkg::MISS_KIND_W-1:0]    miss_kind;
  logic                                 dirty_evict;
  logic [dmcts_pkg::EVICT_TAG_W-1:0]    evicted_tag;

  modport source (output valid, output miss_kind, output dirty_evict, output evicted_tag,
                  input ready);
  modport sink   (input valid, input miss_kind, input dirty_evict, input evicted_tag,
                  output ready);
endinterface

[design/dmcts_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module dmcts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read-before-write: a read and a write to one address in the same cycle
  // return the old contents.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[design/direct_mapped_cache_tag_store_core.sv]
// Tag store of a direct-mapped, write-back, write-allocate cache. Each request transaction
// carries a command (read or write) and a byte address, and produces exactly one result
// transaction: a miss classification (hit, compulsory miss or conflict miss), a flag that
// a dirty line was evicted, and the low eight bits of the evicted line's tag (zero when no
// line was replaced). An access is held in the lookup stage registers after acceptance, then
// its result in the output register; one access can be accepted every cycle while results
// are taken or the output register is empty. The line store and the seen-block store are
// synchronous RAMs, read at acceptance and written back when the access leaves the lookup
// stage, with a one-entry forwarding register covering back-to-back accesses to the same
// line or seen row. The output register lets a new request be accepted while a result still
// waits. After reset the block runs a clearing pass over both RAMs, one entry per cycle;
// no request is accepted until it finishes.
module direct_mapped_cache_tag_store_core #(
  parameter int unsigned ADDR_BITS   = 20,
  parameter int unsigned OFFSET_BITS = 4,
  parameter int unsigned SET_BITS    = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dmcts_req_if.sink    req_i,
  dmcts_rsp_if.source  rsp_o
);

  // Derived geometry. Block and tag widths are kept at least one bit wide so that
  // degenerate address splits still elaborate; the unused bit is always zero.
  localparam int BLOCK_RAW   = int'(ADDR_BITS) - int'(OFFSET_BITS);
  localparam int BLK_W       = (BLOCK_RAW > 1) ? BLOCK_RAW : 1;
  localparam int TAG_RAW     = int'(ADDR_BITS) - int'(OFFSET_BITS) - int'(SET_BITS);
  localparam int TAG_W       = (TAG_RAW > 1) ? TAG_RAW : 1;
  localparam int LINE_W      = TAG_W + 2;
  localparam int EXT_W       = int'(ADDR_BITS) + 32;
  localparam int EVT_W       = int'(dmcts_pkg::EVICT_TAG_W);
  // Seen-block bits are packed 32 to a RAM row, or fewer when the block number is under five bits.
  localparam int SEEN_SEL_W  = (BLK_W > 5) ? 5 : BLK_W;
  localparam int SEEN_ROW_W  = 1 << SEEN_SEL_W;
  localparam int SEEN_AW_RAW = BLK_W - SEEN_SEL_W;
  localparam int SEEN_AW     = (SEEN_AW_RAW > 1) ? SEEN_AW_RAW : 1;
  localparam int CLR_W       = (int'(SET_BITS) > SEEN_AW) ? int'(SET_BITS) : SEEN_AW;

  // Line word layout: {valid, dirty, tag}.
  localparam int LV_BIT = LINE_W - 1;
  localparam int LD_BIT = LINE_W - 2;

  // ---------------------------------------------------------------------------------------
  // Clearing pass after reset.
  // ---------------------------------------------------------------------------------------
  logic             clear_q, clear_d;
  logic [CLR_W-1:0] clr_ptr_q, clr_ptr_d;

  always_comb begin
    clear_d   = clear_q;
    clr_ptr_d = clr_ptr_q;
    if (clear_q) begin
      clr_ptr_d = clr_ptr_q + CLR_W'(1);
      if (clr_ptr_q == {CLR_W{1'b1}}) begin
        clear_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q   <= 1'b1;
      clr_ptr_q <= '0;
    end else begin
      clear_q   <= clear_d;
      clr_ptr_q <= clr_ptr_d;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Address split of the incoming request.
  // ---------------------------------------------------------------------------------------
  logic [EXT_W-1:0]      in_ext, in_blk_ext, in_tag_ext;
  logic [SET_BITS-1:0]   in_idx;
  logic [TAG_W-1:0]      in_tag;
  logic [SEEN_AW-1:0]    in_row;
  logic [SEEN_SEL_W-1:0] in_sel;

  always_comb begin
    in_ext     = EXT_W'(req_i.address);
    in_blk_ext = in_ext >> OFFSET_BITS;
    in_tag_ext = in_ext >> (OFFSET_BITS + SET_BITS);
    in_idx     = in_blk_ext[SET_BITS-1:0];
    in_tag     = in_tag_ext[TAG_W-1:0];
    in_row     = in_blk_ext[SEEN_SEL_W +: SEEN_AW];
    in_sel     = in_blk_ext[SEEN_SEL_W-1:0];
  end

  // ---------------------------------------------------------------------------------------
  // Handshake and lookup stage registers.
  // ---------------------------------------------------------------------------------------
  logic s1_valid_q, s1_adv, out_valid_q, req_acc;

  assign s1_adv      = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !clear_q && (!s1_valid_q || s1_adv);
  assign req_acc     = req_i.valid && req_i.ready;

  logic                  s1_cmd_q;
  logic [SET_BITS-1:0]   s1_idx_q;
  logic [TAG_W-1:0]      s1_tag_q;
  logic [SEEN_AW-1:0]    s1_row_q;
  logic [SEEN_SEL_W-1:0] s1_sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      s1_cmd_q <= req_i.command;
      s1_idx_q <= in_idx;
      s1_tag_q <= in_tag;
      s1_row_q <= in_row;
      s1_sel_q <= in_sel;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Storage: line store and seen-block store.
  // ---------------------------------------------------------------------------------------
  logic                  line_we, seen_we;
  logic [SET_BITS-1:0]   line_waddr;
  logic [SEEN_AW-1:0]    seen_waddr;
  logic [LINE_W-1:0]     line_wdata, line_rdata, line_new;
  logic [SEEN_ROW_W-1:0] seen_wdata, seen_rdata, seen_new;

  assign line_we    = clear_q || s1_adv;
  assign seen_we    = clear_q || s1_adv;
  assign line_waddr = clear_q ? clr_ptr_q[SET_BITS-1:0] : s1_idx_q;
  assign seen_waddr = clear_q ? clr_ptr_q[SEEN_AW-1:0] : s1_row_q;
  assign line_wdata = clear_q ? '0 : line_new;
  assign seen_wdata = clear_q ? '0 : seen_new;

  dmcts_ram #(
    .WIDTH (LINE_W),
    .DEPTH (1 << SET_BITS)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_waddr),
    .wdata_i (line_wdata),
    .re_i    (req_acc),
    .raddr_i (in_idx),
    .rdata_o (line_rdata)
  );

  dmcts_ram #(
    .WIDTH (SEEN_ROW_W),
    .DEPTH (1 << SEEN_AW)
  ) u_seen_ram (
    .clk_i   (clk_i),
    .we_i    (seen_we),
    .waddr_i (seen_waddr),
    .wdata_i (seen_wdata),
    .re_i    (req_acc),
    .raddr_i (in_row),
    .rdata_o (seen_rdata)
  );

  // ---------------------------------------------------------------------------------------
  // Forwarding of the most recent write-back. A read issued in the same cycle as the
  // previous access's write returns stale data, so the last written line and seen row are
  // held here and take precedence when their address matches.
  // ---------------------------------------------------------------------------------------
  logic                  fwd_valid_q;
  logic [SET_BITS-1:0]   fwd_idx_q;
  logic [LINE_W-1:0]     fwd_line_q;
  logic [SEEN_AW-1:0]    fwd_row_q;
  logic [SEEN_ROW_W-1:0] fwd_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (s1_adv) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      fwd_idx_q  <= s1_idx_q;
      fwd_line_q <= line_new;
      fwd_row_q  <= s1_row_q;
      fwd_seen_q <= seen_new;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Classification and update.
  // ---------------------------------------------------------------------------------------
  logic [LINE_W-1:0]      cur_line;
  logic [SEEN_ROW_W-1:0]  cur_seen;
  logic                   cur_valid, cur_dirty, seen_hit, tag_eq;
  logic [TAG_W-1:0]       cur_tag;
  dmcts_pkg::miss_kind_e  kind;
  logic                   evict_dirty;
  logic [EVT_W-1:0]       evict_tag;

  always_comb begin
    cur_line  = (fwd_valid_q && (fwd_idx_q == s1_idx_q)) ? fwd_line_q : line_rdata;
    cur_seen  = (fwd_valid_q && (fwd_row_q == s1_row_q)) ? fwd_seen_q : seen_rdata;
    cur_valid = cur_line[LV_BIT];
    cur_dirty = cur_line[LD_BIT];
    cur_tag   = cur_line[TAG_W-1:0];
    seen_hit  = cur_seen[s1_sel_q];
    tag_eq    = (cur_tag == s1_tag_q);

    if (!seen_hit) begin
      kind = dmcts_pkg::MISS_COMPULSORY;
    end else if (cur_valid && tag_eq) begin
      kind = dmcts_pkg::MISS_HIT;
    end else begin
      kind = dmcts_pkg::MISS_CONFLICT;
    end

    evict_dirty = 1'b0;
    evict_tag   = '0;
    if (cur_valid && tag_eq) begin
      // Same line stays resident; a write makes it dirty.
      line_new = {1'b1, cur_dirty | (s1_cmd_q == dmcts_pkg::CMD_WRITE), s1_tag_q};
    end else begin
      // Fill or replacement: the new line is clean unless this access writes it.
      line_new = {1'b1, (s1_cmd_q == dmcts_pkg::CMD_WRITE), s1_tag_q};
      if (cur_valid) begin
        evict_dirty = cur_dirty;
        evict_tag   = EVT_W'(cur_tag);
      end
    end

    seen_new = cur_seen | (SEEN_ROW_W'(1) << s1_sel_q);
  end

  // ---------------------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------------------
  logic [dmcts_pkg::MISS_KIND_W-1:0] out_kind_q;
  logic                              out_dirty_q;
  logic [EVT_W-1:0]                  out_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_kind_q  <= kind;
      out_dirty_q <= evict_dirty;
      out_tag_q   <= evict_tag;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.miss_kind   = out_kind_q;
  assign rsp_o.dirty_evict = out_dirty_q;
  assign rsp_o.evicted_tag = out_tag_q;

  // ---------------------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------------------
  // Nothing is in flight while the stores are being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_q |-> (!s1_valid_q && !out_valid_q))
    else $error("access in flight during clearing pass");

  // A result only appears after a lookup stage held an access.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result without a preceding lookup");

  // A hit never reports a replacement.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q == dmcts_pkg::MISS_HIT)) |->
      (!out_dirty_q && (out_tag_q == '0)))
    else $error("hit reported with an eviction");

  // The forwarded line is always a resident line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_valid_q |-> fwd_line_q[LV_BIT])
    else $error("forwarded line not valid");

endmodule
